[src/lrs_pkg.sv]
// Shared types, constants and codes of the link reconnect supervisor.
package lrs_pkg;

    localparam int TIME_W_DEFAULT = 32;
    localparam int NOW_W          = 32;
    localparam int CFG_W          = 31;
    localparam int FAIL_W         = 8;
    localparam int CFG_IDX_W      = 3;

    localparam logic [FAIL_W-1:0] FAIL_MAX = '1;

    // Register values after reset.
    localparam logic [CFG_W-1:0]  RST_CONNECT_TIMEOUT = CFG_W'(20000);
    localparam logic [CFG_W-1:0]  RST_AP_AFTER        = CFG_W'(90000);
    localparam logic [CFG_W-1:0]  RST_AP_RETRY        = CFG_W'(60000);
    localparam logic [CFG_W-1:0]  RST_AP_LINGER       = CFG_W'(5 * 60 * 1000);
    localparam logic [FAIL_W-1:0] RST_DROP_LOCK_AFTER = FAIL_W'(3);
    localparam logic [CFG_W-1:0]  RST_AP_START_BACKOFF = CFG_W'(5000);
    localparam logic [CFG_W-1:0]  RST_BASE_BACKOFF    = CFG_W'(5000);
    localparam logic [CFG_W-1:0]  RST_MAX_BACKOFF     = CFG_W'(60000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONNECT_TIMEOUT  = 3'd0,
        CFG_AP_AFTER         = 3'd1,
        CFG_AP_RETRY         = 3'd2,
        CFG_AP_LINGER        = 3'd3,
        CFG_DROP_LOCK_AFTER  = 3'd4,
        CFG_AP_START_BACKOFF = 3'd5,
        CFG_BASE_BACKOFF     = 3'd6,
        CFG_MAX_BACKOFF      = 3'd7
    } lrs_cfg_idx_t;

    typedef enum logic [1:0] {
        PH_IDLE       = 2'd0,
        PH_CONNECTING = 2'd1,
        PH_CONNECTED  = 2'd2
    } lrs_phase_t;

    typedef struct packed {
        logic [CFG_W-1:0]  connect_timeout_ms;
        logic [CFG_W-1:0]  ap_after_ms;
        logic [CFG_W-1:0]  ap_retry_ms;
        logic [CFG_W-1:0]  ap_linger_ms;
        logic [FAIL_W-1:0] drop_lock_after;
        logic [CFG_W-1:0]  ap_start_backoff_ms;
        logic [CFG_W-1:0]  base_backoff_ms;
        logic [CFG_W-1:0]  max_backoff_ms;
    } lrs_cfg_t;

    // Control part of the supervisor state; timestamps travel separately
    // because their width is a module parameter.
    typedef struct packed {
        lrs_phase_t        phase;
        logic [CFG_W-1:0]  backoff;
        logic [FAIL_W-1:0] fail_run;
        logic              lock_dropped;
        logic              ap_up;
        logic              announce_up;
    } lrs_ctl_t;

    typedef struct packed {
        logic             kind;
        logic [NOW_W-1:0] now_ms;
        logic             link_up;
        logic             have_credentials;
        logic             lock_requested;
        logic             lock_address_valid;
        logic             ap_start_ok;
    } lrs_in_t;

    typedef struct packed {
        logic [1:0]        link_state;
        logic              ap_active;
        logic              begin_connect;
        logic              connect_locked;
        logic              ap_start_tried;
        logic              ap_stop;
        logic              connected_event;
        logic              announce_start;
        logic              announce_stop;
        logic [FAIL_W-1:0] failed_count;
        logic [CFG_W-1:0]  retry_delay_ms;
    } lrs_out_t;

endpackage

[src/lrs_if.sv]
// Valid/ready channel interfaces for event beats and result beats.
interface lrs_in_if;
    import lrs_pkg::*;

    logic    valid;
    logic    ready;
    lrs_in_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface lrs_out_if;
    import lrs_pkg::*;

    logic     valid;
    logic     ready;
    lrs_out_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[src/lrs_step.sv]
// Next-state and result logic for one event of the link reconnect supervisor.
module lrs_step #(
    parameter int TIME_WIDTH = lrs_pkg::TIME_W_DEFAULT
) (
    input  lrs_pkg::lrs_cfg_t        cfg,
    input  lrs_pkg::lrs_in_t         item,
    input  lrs_pkg::lrs_ctl_t        ctl,
    input  logic [TIME_WIDTH-1:0]    phase_since,
    input  logic [TIME_WIDTH-1:0]    next_attempt_at,
    input  logic [TIME_WIDTH-1:0]    down_since,
    input  logic [TIME_WIDTH-1:0]    ap_retry_at,
    input  logic [TIME_WIDTH-1:0]    linger_until,
    output lrs_pkg::lrs_ctl_t        ctl_next,
    output logic [TIME_WIDTH-1:0]    phase_since_next,
    output logic [TIME_WIDTH-1:0]    next_attempt_at_next,
    output logic [TIME_WIDTH-1:0]    down_since_next,
    output logic [TIME_WIDTH-1:0]    ap_retry_at_next,
    output logic [TIME_WIDTH-1:0]    linger_until_next,
    output lrs_pkg::lrs_out_t        result
);
    import lrs_pkg::*;

    localparam int CMP_W = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;

    // A time is reached when the wrapped difference has its top bit clear.
    function automatic logic reached(input logic [TIME_WIDTH-1:0] now_t,
                                     input logic [TIME_WIDTH-1:0] at_t);
        logic [TIME_WIDTH-1:0] diff;
        diff = now_t - at_t;
        return !diff[TIME_WIDTH-1];
    endfunction

    logic [TIME_WIDTH-1:0] now_t;
    logic [TIME_WIDTH-1:0] phase_elapsed;
    logic [TIME_WIDTH-1:0] down_elapsed;
    logic [TIME_WIDTH-1:0] ap_retry_base;
    logic [FAIL_W-1:0]     fail_inc;
    logic [CFG_W-1:0]      backoff_grown;
    logic                  ap_try;

    assign now_t         = TIME_WIDTH'(item.now_ms);
    assign phase_elapsed = now_t - phase_since;
    assign fail_inc      = (ctl.fail_run == FAIL_MAX) ? ctl.fail_run
                                                      : ctl.fail_run + FAIL_W'(1);

    always_comb
    begin
        ctl_next             = ctl;
        phase_since_next     = phase_since;
        next_attempt_at_next = next_attempt_at;
        down_since_next      = down_since;
        linger_until_next    = linger_until;
        ap_retry_base        = ap_retry_at;
        ap_try               = 1'b0;
        backoff_grown        = ctl.backoff;
        down_elapsed         = '0;
        result               = '0;

        if (item.kind)
        begin
            // Reconfigure: fresh start of the retry bookkeeping.
            ctl_next.lock_dropped = 1'b0;
            ctl_next.fail_run     = '0;
            ctl_next.backoff      = cfg.base_backoff_ms;
            ctl_next.announce_up  = 1'b0;
            down_since_next       = '0;
            ap_retry_base         = '0;
            if (item.have_credentials)
            begin
                result.begin_connect  = 1'b1;
                result.connect_locked = item.lock_requested && item.lock_address_valid;
                ctl_next.phase        = PH_CONNECTING;
                phase_since_next      = now_t;
                down_since_next       = now_t;
            end
            else
            begin
                ap_try = 1'b1;
            end
        end
        else
        begin
            unique case (ctl.phase)
                PH_IDLE:
                begin
                    if (!item.have_credentials)
                    begin
                        ap_try = 1'b1;
                    end
                    else if (reached(now_t, next_attempt_at))
                    begin
                        result.begin_connect  = 1'b1;
                        result.connect_locked = item.lock_requested && !ctl.lock_dropped
                                                && item.lock_address_valid;
                        ctl_next.phase        = PH_CONNECTING;
                        phase_since_next      = now_t;
                        if (down_since == '0)
                        begin
                            down_since_next = now_t;
                        end
                    end
                end
                PH_CONNECTING:
                begin
                    if (item.link_up)
                    begin
                        ctl_next.phase        = PH_CONNECTED;
                        phase_since_next      = now_t;
                        ctl_next.backoff      = cfg.base_backoff_ms;
                        ctl_next.fail_run     = '0;
                        ctl_next.lock_dropped = 1'b0;
                        down_since_next       = '0;
                        result.connected_event = 1'b1;
                        if (!ctl.announce_up)
                        begin
                            ctl_next.announce_up  = 1'b1;
                            result.announce_start = 1'b1;
                        end
                        if (ctl.ap_up)
                        begin
                            linger_until_next = now_t + TIME_WIDTH'(cfg.ap_linger_ms);
                        end
                    end
                    else if (CMP_W'(phase_elapsed) >= CMP_W'(cfg.connect_timeout_ms))
                    begin
                        ctl_next.fail_run = fail_inc;
                        if (fail_inc == cfg.drop_lock_after && item.lock_requested
                            && !ctl.lock_dropped)
                        begin
                            ctl_next.lock_dropped = 1'b1;
                        end
                        ctl_next.phase       = PH_IDLE;
                        next_attempt_at_next = now_t + TIME_WIDTH'(ctl.backoff);
                        // Below half the cap the shift cannot overflow.
                        if (ctl.backoff < (cfg.max_backoff_ms >> 1))
                        begin
                            backoff_grown = {ctl.backoff[CFG_W-2:0], 1'b0};
                        end
                        else
                        begin
                            backoff_grown = cfg.max_backoff_ms;
                        end
                        if (ctl.ap_up && backoff_grown < cfg.ap_retry_ms)
                        begin
                            backoff_grown = cfg.ap_retry_ms;
                        end
                        ctl_next.backoff = backoff_grown;
                    end
                end
                PH_CONNECTED:
                begin
                    if (!item.link_up)
                    begin
                        ctl_next.phase       = PH_IDLE;
                        next_attempt_at_next = now_t;
                        ctl_next.backoff     = cfg.base_backoff_ms;
                        down_since_next      = now_t;
                        ctl_next.announce_up = 1'b0;
                        result.announce_stop = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase

            // Continuous downtime raises the setup access point.
            down_elapsed = now_t - down_since_next;
            if (!ctl.ap_up && ctl_next.phase != PH_CONNECTED && down_since_next != '0
                && CMP_W'(down_elapsed) >= CMP_W'(cfg.ap_after_ms))
            begin
                ap_try = 1'b1;
            end
        end

        ap_retry_at_next = ap_retry_base;
        if (ap_try && !ctl.ap_up
            && (ap_retry_base == '0 || reached(now_t, ap_retry_base)))
        begin
            ap_retry_at_next      = now_t + TIME_WIDTH'(cfg.ap_start_backoff_ms);
            result.ap_start_tried = 1'b1;
            ctl_next.ap_up        = item.ap_start_ok;
        end

        // Once connected, the access point closes after its linger time.
        if (!item.kind && ctl.ap_up && ctl_next.phase == PH_CONNECTED
            && linger_until_next != '0 && reached(now_t, linger_until_next))
        begin
            linger_until_next = '0;
            ctl_next.ap_up    = 1'b0;
            ap_retry_at_next  = '0;
            result.ap_stop    = 1'b1;
        end

        result.link_state     = ctl_next.phase;
        result.ap_active      = ctl_next.ap_up;
        result.failed_count   = ctl_next.fail_run;
        result.retry_delay_ms = ctl_next.backoff;
    end

endmodule

[src/link_reconnect_supervisor.sv]
// Top level of the link reconnect supervisor: configuration, pipeline and state.
//
// The supervisor takes one event beat per clock cycle while the result side
// keeps up, and returns one result beat for each from the output register.
// An accepted beat is held in an input register; in the next cycle the
// decision logic in lrs_step works from that register and the supervisor
// state, and at the same clock edge the state is updated and the result is
// loaded into the output register. Both registers advance together whenever
// the output register is empty or its beat is being taken, so a waiting
// result does not stop the next event from being accepted, and a stalled
// result side holds at most one event in the input register. Configuration
// registers are written through cfg_wr_en, cfg_index and cfg_data and should
// only change while no event is in flight. Timestamps are kept TIME_WIDTH
// bits wide and compared modulo 2^TIME_WIDTH; a stored timestamp of zero
// means "not set".
module link_reconnect_supervisor #(
    parameter int TIME_WIDTH = lrs_pkg::TIME_W_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [lrs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lrs_pkg::CFG_W-1:0]     cfg_data,
    lrs_in_if.sink                        step,
    lrs_out_if.source                     result
);
    import lrs_pkg::*;

    // Configuration registers.
    lrs_cfg_t cfg_reg;

    // Pipeline registers.
    logic     stage_valid_reg;
    lrs_in_t  stage_reg;
    logic     out_valid_reg;
    lrs_out_t out_reg;

    // Supervisor state.
    lrs_ctl_t              ctl_reg;
    logic [TIME_WIDTH-1:0] phase_since_reg;
    logic [TIME_WIDTH-1:0] next_attempt_at_reg;
    logic [TIME_WIDTH-1:0] down_since_reg;
    logic [TIME_WIDTH-1:0] ap_retry_at_reg;
    logic [TIME_WIDTH-1:0] linger_until_reg;

    lrs_ctl_t              ctl_next;
    logic [TIME_WIDTH-1:0] phase_since_next;
    logic [TIME_WIDTH-1:0] next_attempt_at_next;
    logic [TIME_WIDTH-1:0] down_since_next;
    logic [TIME_WIDTH-1:0] ap_retry_at_next;
    logic [TIME_WIDTH-1:0] linger_until_next;
    lrs_out_t              out_next;

    logic advance;
    logic take_in;

    // The whole pipeline moves when the output register can accept a beat.
    assign advance        = !out_valid_reg || result.ready;
    assign step.ready     = !stage_valid_reg || advance;
    assign take_in        = step.valid && step.ready;
    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.connect_timeout_ms  <= RST_CONNECT_TIMEOUT;
            cfg_reg.ap_after_ms         <= RST_AP_AFTER;
            cfg_reg.ap_retry_ms         <= RST_AP_RETRY;
            cfg_reg.ap_linger_ms        <= RST_AP_LINGER;
            cfg_reg.drop_lock_after     <= RST_DROP_LOCK_AFTER;
            cfg_reg.ap_start_backoff_ms <= RST_AP_START_BACKOFF;
            cfg_reg.base_backoff_ms     <= RST_BASE_BACKOFF;
            cfg_reg.max_backoff_ms      <= RST_MAX_BACKOFF;
        end
        else if (cfg_wr_en)
        begin
            unique case (lrs_cfg_idx_t'(cfg_index))
                CFG_CONNECT_TIMEOUT:  cfg_reg.connect_timeout_ms  <= cfg_data;
                CFG_AP_AFTER:         cfg_reg.ap_after_ms         <= cfg_data;
                CFG_AP_RETRY:         cfg_reg.ap_retry_ms         <= cfg_data;
                CFG_AP_LINGER:        cfg_reg.ap_linger_ms        <= cfg_data;
                CFG_DROP_LOCK_AFTER:  cfg_reg.drop_lock_after     <= cfg_data[FAIL_W-1:0];
                CFG_AP_START_BACKOFF: cfg_reg.ap_start_backoff_ms <= cfg_data;
                CFG_BASE_BACKOFF:     cfg_reg.base_backoff_ms     <= cfg_data;
                CFG_MAX_BACKOFF:      cfg_reg.max_backoff_ms      <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (step.ready)
        begin
            stage_valid_reg <= step.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            stage_reg <= step.payload;
        end
    end

    lrs_step #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_step (
        .cfg                  (cfg_reg),
        .item                 (stage_reg),
        .ctl                  (ctl_reg),
        .phase_since          (phase_since_reg),
        .next_attempt_at      (next_attempt_at_reg),
        .down_since           (down_since_reg),
        .ap_retry_at          (ap_retry_at_reg),
        .linger_until         (linger_until_reg),
        .ctl_next             (ctl_next),
        .phase_since_next     (phase_since_next),
        .next_attempt_at_next (next_attempt_at_next),
        .down_since_next      (down_since_next),
        .ap_retry_at_next     (ap_retry_at_next),
        .linger_until_next    (linger_until_next),
        .result               (out_next)
    );

    // State and output register update together as an event leaves the
    // input register, so the next event always sees the updated state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg       <= 1'b0;
            ctl_reg.phase       <= PH_IDLE;
            ctl_reg.backoff     <= RST_BASE_BACKOFF;
            ctl_reg.fail_run    <= '0;
            ctl_reg.lock_dropped <= 1'b0;
            ctl_reg.ap_up       <= 1'b0;
            ctl_reg.announce_up <= 1'b0;
            phase_since_reg     <= '0;
            next_attempt_at_reg <= '0;
            down_since_reg      <= '0;
            ap_retry_at_reg     <= '0;
            linger_until_reg    <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= stage_valid_reg;
            if (stage_valid_reg)
            begin
                ctl_reg             <= ctl_next;
                phase_since_reg     <= phase_since_next;
                next_attempt_at_reg <= next_attempt_at_next;
                down_since_reg      <= down_since_next;
                ap_retry_at_reg     <= ap_retry_at_next;
                linger_until_reg    <= linger_until_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && stage_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    // An event leaving the input register always produces a result beat.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && stage_valid_reg) |=> out_valid_reg)
        else $error("event left the input register without a result beat");

    // The access point only comes up through a start attempt of the event
    // whose result has just been loaded.
    a_ap_rise_tried: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ctl_reg.ap_up) |-> (out_valid_reg && out_reg.ap_start_tried))
        else $error("access point came up without a start attempt");

    // A dropped lock always follows at least one counted failure.
    a_lock_drop_has_failures: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.lock_dropped |-> (ctl_reg.fail_run != '0))
        else $error("lock dropped with an empty failure count");

    // While connected, no downtime is being measured.
    a_connected_not_down: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_reg.phase == PH_CONNECTED) |-> (down_since_reg == '0))
        else $error("downtime set while connected");

endmodule

[dv/lrs_supervisor_checker.sv]
// Result checker for the link reconnect supervisor: predicts each result beat and compares it.
`timescale 1ns / 1ps

module lrs_supervisor_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [lrs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lrs_pkg::CFG_W-1:0]     cfg_data,
    lrs_in_if                             step,
    lrs_out_if                            result,
    input  logic                          run_done,
    output int                            mismatches,
    output int                            results_checked,
    output int                            connects_seen,
    output int                            ap_tries_seen
);
    import lrs_pkg::*;

    // Register copy and supervisor state, kept as the block keeps them.
    lrs_cfg_t    cfg_copy;
    lrs_phase_t  phase;
    logic [31:0] phase_since;
    logic [31:0] next_attempt_at;
    logic [31:0] down_since;
    logic [31:0] backoff;
    logic [7:0]  fail_run;
    logic        lock_dropped;
    logic        ap_up;
    logic [31:0] ap_retry_at;
    logic [31:0] linger_until;
    logic        announce_up;

    lrs_out_t pending_decisions[$];
    lrs_out_t want;
    logic     leftovers_reported;

    // A time is reached when the wrapped difference has its top bit clear.
    function automatic logic time_reached(input logic [31:0] now, input logic [31:0] at);
        logic [31:0] diff;
        diff = now - at;
        return !diff[31];
    endfunction

    function automatic void raise_ap(inout lrs_out_t r, input logic [31:0] now, input logic ok);
        if (ap_up)
            return;
        if (ap_retry_at != 0 && !time_reached(now, ap_retry_at))
            return;
        ap_retry_at = now + 32'(cfg_copy.ap_start_backoff_ms);
        r.ap_start_tried = 1'b1;
        if (ok)
            ap_up = 1'b1;
    endfunction

    function automatic void open_attempt(inout lrs_out_t r, input lrs_in_t ev);
        r.begin_connect  = 1'b1;
        r.connect_locked = ev.lock_requested && !lock_dropped && ev.lock_address_valid;
        phase            = PH_CONNECTING;
        phase_since      = ev.now_ms;
        if (down_since == 0)
            down_since = ev.now_ms;
    endfunction

    function automatic lrs_out_t decide_step(input lrs_in_t ev);
        lrs_out_t    r;
        logic [31:0] now;
        r   = '0;
        now = ev.now_ms;
        if (ev.kind) begin
            // Reconfigure: a fresh start with the downtime and linger checks skipped.
            lock_dropped = 1'b0;
            fail_run     = '0;
            backoff      = 32'(cfg_copy.base_backoff_ms);
            down_since   = '0;
            ap_retry_at  = '0;
            announce_up  = 1'b0;
            if (ev.have_credentials)
                open_attempt(r, ev);
            else
                raise_ap(r, now, ev.ap_start_ok);
        end
        else begin
            case (phase)
                PH_IDLE: begin
                    if (!ev.have_credentials)
                        raise_ap(r, now, ev.ap_start_ok);
                    else if (time_reached(now, next_attempt_at))
                        open_attempt(r, ev);
                end
                PH_CONNECTING: begin
                    if (ev.link_up) begin
                        phase             = PH_CONNECTED;
                        phase_since       = now;
                        backoff           = 32'(cfg_copy.base_backoff_ms);
                        fail_run          = '0;
                        lock_dropped      = 1'b0;
                        down_since        = '0;
                        r.connected_event = 1'b1;
                        if (!announce_up) begin
                            announce_up      = 1'b1;
                            r.announce_start = 1'b1;
                        end
                        if (ap_up)
                            linger_until = now + 32'(cfg_copy.ap_linger_ms);
                    end
                    else if ((now - phase_since) >= 32'(cfg_copy.connect_timeout_ms)) begin
                        if (fail_run != FAIL_MAX)
                            fail_run++;
                        if (fail_run == cfg_copy.drop_lock_after && ev.lock_requested &&
                            !lock_dropped)
                            lock_dropped = 1'b1;
                        phase           = PH_IDLE;
                        next_attempt_at = now + backoff;
                        if (backoff < 32'(cfg_copy.max_backoff_ms >> 1))
                            backoff = backoff << 1;
                        else
                            backoff = 32'(cfg_copy.max_backoff_ms);
                        if (ap_up && backoff < 32'(cfg_copy.ap_retry_ms))
                            backoff = 32'(cfg_copy.ap_retry_ms);
                    end
                end
                PH_CONNECTED: begin
                    if (!ev.link_up) begin
                        phase           = PH_IDLE;
                        next_attempt_at = now;
                        backoff         = 32'(cfg_copy.base_backoff_ms);
                        down_since      = now;
                        announce_up     = 1'b0;
                        r.announce_stop = 1'b1;
                    end
                end
                default: ;
            endcase
            if (!ap_up && phase != PH_CONNECTED && down_since != 0 &&
                (now - down_since) >= 32'(cfg_copy.ap_after_ms))
                raise_ap(r, now, ev.ap_start_ok);
            if (ap_up && phase == PH_CONNECTED && linger_until != 0 &&
                time_reached(now, linger_until)) begin
                linger_until = '0;
                ap_up        = 1'b0;
                ap_retry_at  = '0;
                r.ap_stop    = 1'b1;
            end
        end
        r.link_state     = phase;
        r.ap_active      = ap_up;
        r.failed_count   = fail_run;
        r.retry_delay_ms = backoff[CFG_W-1:0];
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_v, got_v);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_copy.connect_timeout_ms  = RST_CONNECT_TIMEOUT;
            cfg_copy.ap_after_ms         = RST_AP_AFTER;
            cfg_copy.ap_retry_ms         = RST_AP_RETRY;
            cfg_copy.ap_linger_ms        = RST_AP_LINGER;
            cfg_copy.drop_lock_after     = RST_DROP_LOCK_AFTER;
            cfg_copy.ap_start_backoff_ms = RST_AP_START_BACKOFF;
            cfg_copy.base_backoff_ms     = RST_BASE_BACKOFF;
            cfg_copy.max_backoff_ms      = RST_MAX_BACKOFF;
            phase              = PH_IDLE;
            phase_since        = '0;
            next_attempt_at    = '0;
            down_since         = '0;
            backoff            = 32'(RST_BASE_BACKOFF);
            fail_run           = '0;
            lock_dropped       = 1'b0;
            ap_up              = 1'b0;
            ap_retry_at        = '0;
            linger_until       = '0;
            announce_up        = 1'b0;
            pending_decisions.delete();
            leftovers_reported = 1'b0;
            mismatches         = 0;
            results_checked    = 0;
            connects_seen      = 0;
            ap_tries_seen      = 0;
        end
        else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_CONNECT_TIMEOUT:  cfg_copy.connect_timeout_ms  = cfg_data;
                    CFG_AP_AFTER:         cfg_copy.ap_after_ms         = cfg_data;
                    CFG_AP_RETRY:         cfg_copy.ap_retry_ms         = cfg_data;
                    CFG_AP_LINGER:        cfg_copy.ap_linger_ms        = cfg_data;
                    CFG_DROP_LOCK_AFTER:  cfg_copy.drop_lock_after     = cfg_data[FAIL_W-1:0];
                    CFG_AP_START_BACKOFF: cfg_copy.ap_start_backoff_ms = cfg_data;
                    CFG_BASE_BACKOFF:     cfg_copy.base_backoff_ms     = cfg_data;
                    CFG_MAX_BACKOFF:      cfg_copy.max_backoff_ms      = cfg_data;
                    default: ;
                endcase
            end
            if (step.valid && step.ready) begin
                want = decide_step(step.payload);
                pending_decisions.push_back(want);
                if (want.connected_event)
                    connects_seen++;
                if (want.ap_start_tried)
                    ap_tries_seen++;
            end
            if (result.valid && result.ready) begin
                results_checked++;
                if (pending_decisions.size() == 0) begin
                    $display("%0t ns: result beat with nothing expected, actual %p",
                             $time, result.payload);
                    mismatches++;
                end
                else begin
                    want = pending_decisions.pop_front();
                    check_field("link_state", 32'(want.link_state),
                                32'(result.payload.link_state));
                    check_field("ap_active", 32'(want.ap_active),
                                32'(result.payload.ap_active));
                    check_field("begin_connect", 32'(want.begin_connect),
                                32'(result.payload.begin_connect));
                    check_field("connect_locked", 32'(want.connect_locked),
                                32'(result.payload.connect_locked));
                    check_field("ap_start_tried", 32'(want.ap_start_tried),
                                32'(result.payload.ap_start_tried));
                    check_field("ap_stop", 32'(want.ap_stop),
                                32'(result.payload.ap_stop));
                    check_field("connected_event", 32'(want.connected_event),
                                32'(result.payload.connected_event));
                    check_field("announce_start", 32'(want.announce_start),
                                32'(result.payload.announce_start));
                    check_field("announce_stop", 32'(want.announce_stop),
                                32'(result.payload.announce_stop));
                    check_field("failed_count", 32'(want.failed_count),
                                32'(result.payload.failed_count));
                    check_field("retry_delay_ms", 32'(want.retry_delay_ms),
                                32'(result.payload.retry_delay_ms));
                end
            end
            if (run_done && !leftovers_reported) begin
                leftovers_reported = 1'b1;
                if (pending_decisions.size() != 0) begin
                    $display("%0t ns: %0d expected result beats never arrived, expected %p",
                             $time, pending_decisions.size(), pending_decisions[0]);
                    mismatches += pending_decisions.size();
                end
            end
        end
    end

endmodule

[dv/tb_link_reconnect_supervisor.sv]
// Testbench top for the link reconnect supervisor: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_link_reconnect_supervisor;
    import lrs_pkg::*;

    // Event kinds carried in the kind field of an event beat.
    localparam logic EV_TICK     = 1'b0;
    localparam logic EV_RECONFIG = 1'b1;

    // Register setups run after the directed part; setup 0 keeps the reset values.
    localparam int SETUPS        = 10;
    localparam int SATURATE_SETUP = 4;
    localparam int BEATS_PER_SETUP = 85;
    localparam int SATURATE_BEATS  = 540;

    // Generous bound for roughly 1300 beats in the slowest idling pattern.
    localparam int CYCLE_LIMIT = 200000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 run_done;

    lrs_in_if  step_ch();
    lrs_out_if result_ch();

    int mismatches;
    int results_checked;
    int connects_seen;
    int ap_tries_seen;
    int sent = 0;
    int cycles = 0;

    // Idling knobs: percent of cycles in which the sender holds off, and in which
    // the result side refuses a beat.
    int send_gap_pct = 0;
    int recv_stall_pct = 0;

    // Environment model behind the random beats: a running millisecond clock, a radio
    // that stays up or down for stretches, and credentials that come and go.
    logic [31:0] clock_ms;
    logic [31:0] step_max;
    logic        radio_up;
    logic        creds_on;

    link_reconnect_supervisor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (step_ch),
        .result    (result_ch)
    );

    lrs_supervisor_checker supervisor_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .step            (step_ch),
        .result          (result_ch),
        .run_done        (run_done),
        .mismatches      (mismatches),
        .results_checked (results_checked),
        .connects_seen   (connects_seen),
        .ap_tries_seen   (ap_tries_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // The result side accepts or stalls afresh on every edge, so stalls land on
    // every phase of the block's two-stage pipeline.
    always @(posedge clk)
    begin
        result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Run stopped by the watchdog after %0d cycles", cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic lrs_in_t make_event(input logic kind, input logic [31:0] now_ms,
                                           input logic link_up, input logic creds,
                                           input logic lock_req, input logic addr_ok,
                                           input logic ap_ok);
        lrs_in_t ev;
        ev.kind               = kind;
        ev.now_ms             = now_ms;
        ev.link_up            = link_up;
        ev.have_credentials   = creds;
        ev.lock_requested     = lock_req;
        ev.lock_address_valid = addr_ok;
        ev.ap_start_ok        = ap_ok;
        return ev;
    endfunction

    // Offers one event beat and returns at the edge where it is taken. Valid stays
    // high into the next call, so back-to-back beats need no extra assignment.
    task automatic send_beat(input lrs_in_t ev);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            step_ch.valid <= 1'b0;
            @(posedge clk);
        end
        step_ch.valid   <= 1'b1;
        step_ch.payload <= ev;
        @(posedge clk);
        while (!step_ch.ready)
            @(posedge clk);
        sent++;
    endtask

    // Drops valid and waits until every beat sent has come back, plus a short
    // margin for the two-stage pipeline, so registers can be written safely.
    task automatic drain;
        step_ch.valid <= 1'b0;
        while (results_checked != sent)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        logic [CFG_W-1:0] reg_val [8];
        logic [31:0]      scale;
        int               beats;
        int               up_pct;
        int               kind_pct;
        int               noise_pct;
        logic             creds_pinned;
        lrs_in_t          ev;
        int               roll;

        rst_n           <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_index       <= CFG_CONNECT_TIMEOUT;
        cfg_data        <= '0;
        step_ch.valid   <= 1'b0;
        step_ch.payload <= '0;
        run_done        <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, on the reset register values.
        // With no credentials the setup AP is tried at time zero and fails, waits out its
        // start backoff, and then comes up.
        send_beat(make_event(EV_TICK, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_beat(make_event(EV_TICK, 32'd1000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_beat(make_event(EV_TICK, 32'd5000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        // A reconfigure with credentials starts an attempt locked to one AP.
        send_beat(make_event(EV_RECONFIG, 32'd6000, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0));
        // Three timeouts in a row drop the lock; with the AP up the backoff is floored
        // at the AP retry value.
        send_beat(make_event(EV_TICK, 32'd26000, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0));
        send_beat(make_event(EV_TICK, 32'd31000, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0));
        send_beat(make_event(EV_TICK, 32'd51000, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0));
        send_beat(make_event(EV_TICK, 32'd111000, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0));
        send_beat(make_event(EV_TICK, 32'd131000, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0));
        send_beat(make_event(EV_TICK, 32'd191000, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0));
        // The link comes up, announcement starts, and the AP closes once it has lingered.
        send_beat(make_event(EV_TICK, 32'd192000, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
        send_beat(make_event(EV_TICK, 32'd200000, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
        send_beat(make_event(EV_TICK, 32'd492000, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
        // Link loss stops announcement and retries at once; long downtime raises the AP.
        send_beat(make_event(EV_TICK, 32'd500000, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0));
        send_beat(make_event(EV_TICK, 32'd500001, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0));
        send_beat(make_event(EV_TICK, 32'd591000, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1));
        // Times at the wrap of the millisecond counter, where a zero time reads as unset.
        send_beat(make_event(EV_RECONFIG, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1));
        send_beat(make_event(EV_TICK, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
        send_beat(make_event(EV_TICK, 32'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
        send_beat(make_event(EV_RECONFIG, 32'd0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1));
        send_beat(make_event(EV_TICK, 32'd30000, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0));
        send_beat(make_event(EV_TICK, 32'h8000_0000, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
        send_beat(make_event(EV_TICK, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));

        clock_ms = 32'h7FFF_FFFF;
        radio_up = 1'b0;
        creds_on = 1'b1;

        for (int setup = 0; setup < SETUPS; setup++) begin
            drain();

            // The four idling patterns rotate over the setups; the long saturation
            // setup runs with no idling at all.
            case (setup % 4)
                1:       begin send_gap_pct = 68; recv_stall_pct = 0;  end
                2:       begin send_gap_pct = 0;  recv_stall_pct = 68; end
                3:       begin send_gap_pct = 34; recv_stall_pct = 34; end
                default: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            endcase

            beats        = BEATS_PER_SETUP;
            up_pct       = 8;
            kind_pct     = 3;
            creds_pinned = 1'b0;

            // Pick the register values for this setup. Time advances in steps scaled
            // to the registers, so timeouts, backoffs, downtime and linger all expire.
            case (setup)
                0: step_max = 32'd25000;
                1: begin
                    reg_val[CFG_CONNECT_TIMEOUT]  = 31'd50;
                    reg_val[CFG_AP_AFTER]         = 31'd300;
                    reg_val[CFG_AP_RETRY]         = 31'd80;
                    reg_val[CFG_AP_LINGER]        = 31'd200;
                    reg_val[CFG_DROP_LOCK_AFTER]  = 31'd3;
                    reg_val[CFG_AP_START_BACKOFF] = 31'd40;
                    reg_val[CFG_BASE_BACKOFF]     = 31'd10;
                    reg_val[CFG_MAX_BACKOFF]      = 31'd160;
                    step_max = 32'd60;
                end
                2: begin
                    // Every register at its top value; time jumps cover all its bits.
                    foreach (reg_val[i])
                        reg_val[i] = '1;
                    reg_val[CFG_DROP_LOCK_AFTER] = 31'd255;
                    step_max = 32'h7FFF_FFFF;
                end
                3: begin
                    reg_val[CFG_CONNECT_TIMEOUT]  = 31'd1;
                    reg_val[CFG_AP_AFTER]         = 31'd1;
                    reg_val[CFG_AP_RETRY]         = 31'd0;
                    reg_val[CFG_AP_LINGER]        = 31'd0;
                    reg_val[CFG_DROP_LOCK_AFTER]  = 31'd1;
                    reg_val[CFG_AP_START_BACKOFF] = 31'd1;
                    reg_val[CFG_BASE_BACKOFF]     = 31'd1;
                    reg_val[CFG_MAX_BACKOFF]      = 31'd2;
                    step_max = 32'd4;
                end
                SATURATE_SETUP: begin
                    // A zero timeout fails each attempt on its first tick and a zero cap
                    // zeroes the backoff. With the radio held down and credentials kept,
                    // attempts fail every other beat until the failure count saturates.
                    reg_val[CFG_CONNECT_TIMEOUT]  = 31'd0;
                    reg_val[CFG_AP_AFTER]         = 31'd40;
                    reg_val[CFG_AP_RETRY]         = 31'd0;
                    reg_val[CFG_AP_LINGER]        = 31'd30;
                    reg_val[CFG_DROP_LOCK_AFTER]  = 31'd2;
                    reg_val[CFG_AP_START_BACKOFF] = 31'd10;
                    reg_val[CFG_BASE_BACKOFF]     = 31'd5;
                    reg_val[CFG_MAX_BACKOFF]      = 31'd0;
                    step_max     = 32'd40;
                    beats        = SATURATE_BEATS;
                    up_pct       = 0;
                    kind_pct     = 0;
                    creds_pinned = 1'b1;
                    radio_up     = 1'b0;
                    creds_on     = 1'b1;
                end
                default: begin
                    // Random setup around a random time scale.
                    scale = 32'd1 << $urandom_range(4, 18);
                    reg_val[CFG_CONNECT_TIMEOUT]  = CFG_W'($urandom_range(1, scale));
                    reg_val[CFG_AP_AFTER]         = CFG_W'($urandom_range(1, scale * 4));
                    reg_val[CFG_AP_RETRY]         = CFG_W'($urandom_range(0, scale * 2));
                    reg_val[CFG_AP_LINGER]        = CFG_W'($urandom_range(0, scale * 4));
                    reg_val[CFG_DROP_LOCK_AFTER]  = CFG_W'($urandom_range(1, 8));
                    reg_val[CFG_AP_START_BACKOFF] = CFG_W'($urandom_range(1, scale));
                    reg_val[CFG_BASE_BACKOFF]     = CFG_W'($urandom_range(1, scale / 2));
                    reg_val[CFG_MAX_BACKOFF]      = CFG_W'($urandom_range(2, scale * 2));
                    step_max = scale / 2;
                end
            endcase

            // Write all eight registers on consecutive edges while nothing is in flight.
            if (setup != 0) begin
                for (int i = 0; i < 8; i++) begin
                    cfg_wr_en <= 1'b1;
                    cfg_index <= CFG_IDX_W'(i);
                    cfg_data  <= reg_val[i];
                    @(posedge clk);
                end
                cfg_wr_en <= 1'b0;
                @(posedge clk);
            end

            noise_pct = (up_pct == 0) ? 0 : 3;

            for (int n = 0; n < beats; n++) begin
                // Mostly a steadily advancing clock, with rare jumps anywhere and
                // rare zero times.
                roll = $urandom_range(0, 99);
                if (roll < 2)
                    clock_ms = $urandom();
                else if (roll < 3)
                    clock_ms = '0;
                else
                    clock_ms = clock_ms + $urandom_range(0, step_max);

                if (radio_up)
                    radio_up = ($urandom_range(0, 99) >= 8);
                else
                    radio_up = ($urandom_range(0, 99) < up_pct);
                if (!creds_pinned && $urandom_range(0, 99) < 4)
                    creds_on = !creds_on;

                ev = make_event(($urandom_range(0, 99) < kind_pct) ? EV_RECONFIG : EV_TICK,
                                clock_ms,
                                radio_up ^ ($urandom_range(0, 99) < noise_pct),
                                creds_on,
                                $urandom_range(0, 99) < 80,
                                $urandom_range(0, 99) < 75,
                                $urandom_range(0, 99) < 60);
                send_beat(ev);
            end
        end

        drain();
        run_done <= 1'b1;
        repeat (3) @(posedge clk);

        $display("Covered %0d event beats over %0d register setups with four idling patterns;",
                 sent, SETUPS);
        $display("%0d result beats checked, %0d connections and %0d AP start attempts seen.",
                 results_checked, connects_seen, ap_tries_seen);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
